[src/wbr_pkg.sv]
// Shared types and constants for the Wiegand bit receiver.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package wbr_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int GAP_W       = 16;
    localparam int MAXB_W      = 8;
    localparam int COUNT_W     = 9;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BITS      = 1'b1;

    localparam logic [GAP_W-1:0]   GAP_RESET      = 16'd250;
    localparam logic [MAXB_W-1:0]  MAX_BITS_RESET = 8'd64;
    localparam logic [GAP_W-1:0]   IDLE_MAX       = 16'hFFFF;
    localparam logic [COUNT_W-1:0] PULSE_MAX      = 9'h1FF;

    // result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    // one classified sample: the results it still has to produce
    typedef struct packed {
        logic               has_zero;
        logic               has_one;
        logic               has_eof;
        logic [COUNT_W-1:0] frame_bits;
    } event_t;

endpackage

[src/wiegand_bit_receiver.sv]
// Top level of the Wiegand bit receiver: front end, event queue, result sequencer.
// Depends on wbr_pkg, wbr_front, wbr_event_fifo, wbr_back.
`timescale 1ns / 1ps

// Channel   Handshake        Payload
// sample    push / full      zero_line, one_line
// result    pop / empty      kind, bit_value, frame_bits, last
// config    cfg_we           cfg_index, cfg_data
//
// One line sample is taken per clock while the event queue has room.
// A sample becomes at most one event; its results pass through the event queue
// and the sequencer's work register into the output register.
// The sequencer drains one result per clock while the output is empty or popped;
// once EVQ_DEPTH events wait, full blocks every sample, idle ones included,
// until the sequencer takes an event.
// Reset clears line state, queue and output; registers return to 250 and 64.

module wiegand_bit_receiver #(
    parameter int EVQ_DEPTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [wbr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wbr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic                            zero_line,
    input  logic                            one_line,
    input  logic                            pop,
    output logic                            empty,
    output logic                            kind,
    output logic                            bit_value,
    output logic [wbr_pkg::COUNT_W-1:0]     frame_bits,
    output logic                            last
);

    logic            sample_take;
    logic            ev_push, ev_valid, ev_take;
    wbr_pkg::event_t ev_in, ev_out;

    assign sample_take = push && !full;

    wbr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample_take (sample_take),
        .zero_line   (zero_line),
        .one_line    (one_line),
        .ev_push     (ev_push),
        .ev_data     (ev_in)
    );

    wbr_event_fifo #(
        .DEPTH (EVQ_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (ev_push),
        .wr_data  (ev_in),
        .full     (full),
        .rd_en    (ev_take),
        .rd_valid (ev_valid),
        .rd_data  (ev_out)
    );

    wbr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ev_valid   (ev_valid),
        .ev_data    (ev_out),
        .ev_take    (ev_take),
        .pop        (pop),
        .empty      (empty),
        .kind       (kind),
        .bit_value  (bit_value),
        .frame_bits (frame_bits),
        .last       (last)
    );

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ev_push |-> !full)
        else $error("event written into a full queue");

    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ev_take |-> ev_valid)
        else $error("event taken from an empty queue");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == wbr_pkg::KIND_EOF) |-> (last && !bit_value && frame_bits != '0))
        else $error("malformed end-of-frame result");

    a_data_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == wbr_pkg::KIND_DATA) |-> (frame_bits == '0))
        else $error("data result carries a frame count");

endmodule

[src/wbr_front.sv]
// Front end: line sampling state, configuration registers, event classification.
// Depends on wbr_pkg.
`timescale 1ns / 1ps

module wbr_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [wbr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wbr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            sample_take,
    input  logic                            zero_line,
    input  logic                            one_line,
    output logic                            ev_push,
    output wbr_pkg::event_t                 ev_data
);

    logic [wbr_pkg::GAP_W-1:0]   gap_threshold_reg;
    logic [wbr_pkg::MAXB_W-1:0]  max_bits_reg;

    logic                        pulse_latched_reg, pulse_latched_next;
    logic                        frame_active_reg, frame_active_next;
    logic [wbr_pkg::GAP_W-1:0]   idle_count_reg, idle_count_next;
    logic [wbr_pkg::COUNT_W-1:0] pulse_count_reg, pulse_count_next;

    logic [wbr_pkg::GAP_W-1:0]   idle_inc;
    logic [wbr_pkg::COUNT_W-1:0] pulse_inc;

    assign idle_inc  = (idle_count_reg == wbr_pkg::IDLE_MAX) ? idle_count_reg
                                                             : idle_count_reg + 1'b1;
    assign pulse_inc = (pulse_count_reg == wbr_pkg::PULSE_MAX) ? pulse_count_reg
                                                               : pulse_count_reg + 1'b1;

    always_comb
    begin
        pulse_latched_next = pulse_latched_reg;
        frame_active_next  = frame_active_reg;
        idle_count_next    = idle_count_reg;
        pulse_count_next   = pulse_count_reg;
        ev_push            = 1'b0;
        ev_data            = '0;
        if (sample_take)
        begin
            if (zero_line && one_line)
            begin
                pulse_latched_next = 1'b0;
                idle_count_next    = idle_inc;
                if (frame_active_reg && idle_inc >= gap_threshold_reg)
                begin
                    ev_push            = 1'b1;
                    ev_data.has_eof    = 1'b1;
                    ev_data.frame_bits = pulse_count_reg;
                    frame_active_next  = 1'b0;
                    idle_count_next    = '0;
                    pulse_count_next   = '0;
                end
            end
            else if (!pulse_latched_reg)
            begin
                // first sample of a new pulse
                ev_push            = 1'b1;
                ev_data.has_zero   = !zero_line;
                ev_data.has_one    = !one_line;
                pulse_latched_next = 1'b1;
                frame_active_next  = 1'b1;
                idle_count_next    = '0;
                pulse_count_next   = pulse_inc;
                if (pulse_inc > {1'b0, max_bits_reg})
                begin
                    ev_data.has_eof    = 1'b1;
                    ev_data.frame_bits = pulse_inc;
                    pulse_latched_next = 1'b0;
                    frame_active_next  = 1'b0;
                    pulse_count_next   = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_threshold_reg <= wbr_pkg::GAP_RESET;
            max_bits_reg      <= wbr_pkg::MAX_BITS_RESET;
            pulse_latched_reg <= 1'b0;
            frame_active_reg  <= 1'b0;
            idle_count_reg    <= '0;
            pulse_count_reg   <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == wbr_pkg::CFG_GAP_THRESHOLD)
                gap_threshold_reg <= cfg_data[wbr_pkg::GAP_W-1:0];
            if (cfg_we && cfg_index == wbr_pkg::CFG_MAX_BITS)
                max_bits_reg <= cfg_data[wbr_pkg::MAXB_W-1:0];
            pulse_latched_reg <= pulse_latched_next;
            frame_active_reg  <= frame_active_next;
            idle_count_reg    <= idle_count_next;
            pulse_count_reg   <= pulse_count_next;
        end
    end

endmodule

[src/wbr_event_fifo.sv]
// Short event queue between front end and result sequencer.
// Depends on wbr_pkg for the event type.
`timescale 1ns / 1ps

module wbr_event_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  wbr_pkg::event_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output wbr_pkg::event_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wbr_pkg::event_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (rd_en)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[src/wbr_back.sv]
// Result sequencer: expands one event into its results, one per cycle while the output
// is empty or popped, into a single output register. Depends on wbr_pkg.
`timescale 1ns / 1ps

module wbr_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        ev_valid,
    input  wbr_pkg::event_t             ev_data,
    output logic                        ev_take,
    input  logic                        pop,
    output logic                        empty,
    output logic                        kind,
    output logic                        bit_value,
    output logic [wbr_pkg::COUNT_W-1:0] frame_bits,
    output logic                        last
);

    wbr_pkg::event_t             work_reg, work_next, work_after;
    logic                        work_valid_reg, work_valid_next;
    logic                        out_valid_reg;
    logic                        out_kind_reg, out_bit_reg, out_last_reg;
    logic [wbr_pkg::COUNT_W-1:0] out_bits_reg;

    logic                        out_free, emit, rem_any;
    logic                        sel_kind, sel_bit;
    logic [wbr_pkg::COUNT_W-1:0] sel_bits;

    assign out_free = !out_valid_reg || pop;
    assign emit     = work_valid_reg && out_free;

    // results leave in order: zero bit, one bit, end of frame
    always_comb
    begin
        work_after = work_reg;
        sel_kind   = wbr_pkg::KIND_DATA;
        sel_bit    = 1'b0;
        sel_bits   = '0;
        if (work_reg.has_zero)
            work_after.has_zero = 1'b0;
        else if (work_reg.has_one)
        begin
            work_after.has_one = 1'b0;
            sel_bit            = 1'b1;
        end
        else
        begin
            work_after.has_eof = 1'b0;
            sel_kind           = wbr_pkg::KIND_EOF;
            sel_bits           = work_reg.frame_bits;
        end
    end

    assign rem_any = work_after.has_zero || work_after.has_one || work_after.has_eof;
    assign ev_take = ev_valid && (!work_valid_reg || (emit && !rem_any));

    always_comb
    begin
        work_valid_next = work_valid_reg;
        work_next       = work_reg;
        if (ev_take)
        begin
            work_valid_next = 1'b1;
            work_next       = ev_data;
        end
        else if (emit)
        begin
            work_valid_next = rem_any;
            work_next       = work_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (emit)
        begin
            out_kind_reg <= sel_kind;
            out_bit_reg  <= sel_bit;
            out_bits_reg <= sel_bits;
            out_last_reg <= !rem_any;
        end
    end

    assign empty      = !out_valid_reg;
    assign kind       = out_kind_reg;
    assign bit_value  = out_bit_reg;
    assign frame_bits = out_bits_reg;
    assign last       = out_last_reg;

endmodule
